/* rtl/shrb_pkg.sv */
`default_nettype none
package shrb_pkg;

   localparam int BUF_SIZE = 64;
   localparam int IDX_W    = $clog2(BUF_SIZE);
   localparam int CNT_W    = IDX_W + 1;
   localparam int CHAR_W   = 8;
   localparam int LEN_W    = 6;
   localparam int CUR_W    = 6;
   localparam int STAT_W   = 2;
   localparam int REQ_W    = 2;

   localparam logic [LEN_W:0]   LEN_LIMIT = (LEN_W + 1)'(BUF_SIZE);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(BUF_SIZE);
   localparam logic [CNT_W-1:0] CNT_EMAX  = CNT_W'(BUF_SIZE - 1);

   localparam logic [REQ_W-1:0] REQ_ENQ  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_DEQ  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_PREV = 2'd2;
   localparam logic [REQ_W-1:0] REQ_NEXT = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_NONE    = 2'd1;
   localparam logic [STAT_W-1:0] ST_BAD_LEN = 2'd2;

   typedef enum logic [2:0] {
      IDX_HOLD  = 3'd0,
      IDX_CUR   = 3'd1,
      IDX_CURM1 = 3'd2,
      IDX_INC   = 3'd3,
      IDX_DEC   = 3'd4,
      IDX_TAIL  = 3'd5,
      IDX_RES   = 3'd6,
      IDX_START = 3'd7
   } idx_op_type;

   typedef enum logic [1:0] {
      START_HOLD  = 2'd0,
      START_IDX   = 2'd1,
      START_IDXP1 = 2'd2,
      START_TAIL  = 2'd3
   } start_op_type;

   typedef enum logic [2:0] {
      EMIT_NONE      = 3'd0,
      EMIT_BAD_LEN   = 3'd1,
      EMIT_FAIL_CUR  = 3'd2,
      EMIT_FAIL_TAIL = 3'd3,
      EMIT_ENQ       = 3'd4,
      EMIT_PEND_MID  = 3'd5,
      EMIT_PEND_LAST = 3'd6,
      EMIT_EMPTY     = 3'd7
   } emit_type;

   typedef struct packed {
      logic         latch;
      idx_op_type   idx_op;
      start_op_type start_op;
      logic         cnt_clr;
      logic         cnt_inc;
      logic         phase_clr;
      logic         phase_set;
      logic         reserve;
      logic         tail_set;
      logic         wr_byte;
      logic         fin_enq;
      logic         em_init;
      logic         pend_load;
      emit_type     emit;
   } cmd_type;

   typedef struct packed {
      logic [REQ_W-1:0] rtype;
      logic             active;
      logic             len_bad;
      logic             last;
      logic             h_eq_t;
      logic             h_eq_cur;
      logic             t_eq_cur;
      logic             push;
      logic             at_head;
      logic             at_tail;
      logic             cnt_full;
      logic             cnt_emax;
      logic             byte_zero;
      logic             phase;
      logic             pend_v;
      logic             store_ok;
      logic             start_eq_cur;
   } sts_type;

endpackage
`default_nettype wire

/* rtl/shrb_ram.sv */
`default_nettype none
module shrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

/* rtl/shrb_ctrl.sv */
`default_nettype none
module shrb_ctrl
   import shrb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire sts_type sts,
   output cmd_type      cmd
);
   typedef enum logic [20:0] {
      S_IDLE     = 21'd1 << 0,
      S_DISP     = 21'd1 << 1,
      S_ENQ_RES  = 21'd1 << 2,
      S_TSEEK_RD = 21'd1 << 3,
      S_TSEEK_EV = 21'd1 << 4,
      S_TSKIP_RD = 21'd1 << 5,
      S_TSKIP_EV = 21'd1 << 6,
      S_ENQ_WR   = 21'd1 << 7,
      S_ENQ_FIN  = 21'd1 << 8,
      S_NSEEK_RD = 21'd1 << 9,
      S_NSEEK_EV = 21'd1 << 10,
      S_NSKIP_RD = 21'd1 << 11,
      S_NSKIP_EV = 21'd1 << 12,
      S_PREV_RD  = 21'd1 << 13,
      S_PREV_EV  = 21'd1 << 14,
      S_PREV_GO  = 21'd1 << 15,
      S_EM_RD    = 21'd1 << 16,
      S_EM_EV    = 21'd1 << 17,
      S_EM_FIN   = 21'd1 << 18,
      S_DSKIP_RD = 21'd1 << 19,
      S_DSKIP_EV = 21'd1 << 20
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_DISP;
            end
         end
         S_DISP: begin
            unique case (sts.rtype)
               REQ_ENQ: begin
                  if (sts.active) begin
                     state_in = S_ENQ_WR;
                  end else if (sts.len_bad) begin
                     cmd.emit = EMIT_BAD_LEN;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_ENQ_RES;
                  end
               end
               REQ_DEQ: begin
                  if (sts.h_eq_t) begin
                     cmd.emit = EMIT_FAIL_TAIL;
                     state_in = S_IDLE;
                  end else begin
                     cmd.idx_op   = IDX_TAIL;
                     cmd.start_op = START_TAIL;
                     cmd.em_init  = 1'b1;
                     state_in     = S_EM_RD;
                  end
               end
               REQ_PREV: begin
                  if (sts.h_eq_t || sts.t_eq_cur) begin
                     cmd.emit = EMIT_FAIL_CUR;
                     state_in = S_IDLE;
                  end else begin
                     cmd.idx_op    = IDX_CURM1;
                     cmd.cnt_clr   = 1'b1;
                     cmd.phase_clr = 1'b1;
                     state_in      = S_PREV_RD;
                  end
               end
               default: begin
                  if (sts.h_eq_t || sts.h_eq_cur) begin
                     cmd.emit = EMIT_FAIL_CUR;
                     state_in = S_IDLE;
                  end else begin
                     cmd.idx_op  = IDX_CUR;
                     cmd.cnt_clr = 1'b1;
                     state_in    = S_NSEEK_RD;
                  end
               end
            endcase
         end
         S_ENQ_RES: begin
            cmd.reserve = 1'b1;
            cmd.idx_op  = IDX_RES;
            cmd.cnt_clr = 1'b1;
            state_in    = sts.push ? S_TSEEK_RD : S_ENQ_WR;
         end
         S_TSEEK_RD: begin
            if (sts.cnt_full) begin
               cmd.cnt_clr = 1'b1;
               state_in    = S_TSKIP_RD;
            end else begin
               state_in = S_TSEEK_EV;
            end
         end
         S_TSEEK_EV: begin
            if (sts.byte_zero) begin
               cmd.cnt_clr = 1'b1;
               state_in    = S_TSKIP_RD;
            end else begin
               cmd.idx_op  = IDX_INC;
               cmd.cnt_inc = 1'b1;
               state_in    = S_TSEEK_RD;
            end
         end
         S_TSKIP_RD: begin
            if (sts.cnt_full) begin
               cmd.tail_set = 1'b1;
               state_in     = S_ENQ_WR;
            end else begin
               state_in = S_TSKIP_EV;
            end
         end
         S_TSKIP_EV: begin
            if (!sts.byte_zero) begin
               cmd.tail_set = 1'b1;
               state_in     = S_ENQ_WR;
            end else begin
               cmd.idx_op  = IDX_INC;
               cmd.cnt_inc = 1'b1;
               state_in    = S_TSKIP_RD;
            end
         end
         S_ENQ_WR: begin
            cmd.wr_byte = sts.store_ok;
            state_in    = sts.last ? S_ENQ_FIN : S_IDLE;
         end
         S_ENQ_FIN: begin
            cmd.fin_enq = 1'b1;
            cmd.emit    = EMIT_ENQ;
            state_in    = S_IDLE;
         end
         S_NSEEK_RD: begin
            if (sts.at_head) begin
               cmd.emit = EMIT_FAIL_CUR;
               state_in = S_IDLE;
            end else if (sts.cnt_full) begin
               cmd.idx_op  = IDX_INC;
               cmd.cnt_clr = 1'b1;
               state_in    = S_NSKIP_RD;
            end else begin
               state_in = S_NSEEK_EV;
            end
         end
         S_NSEEK_EV: begin
            cmd.idx_op = IDX_INC;
            if (sts.byte_zero) begin
               cmd.cnt_clr = 1'b1;
               state_in    = S_NSKIP_RD;
            end else begin
               cmd.cnt_inc = 1'b1;
               state_in    = S_NSEEK_RD;
            end
         end
         S_NSKIP_RD: begin
            if (sts.at_head) begin
               cmd.emit = EMIT_FAIL_CUR;
               state_in = S_IDLE;
            end else if (sts.cnt_full) begin
               cmd.start_op = START_IDX;
               cmd.em_init  = 1'b1;
               state_in     = S_EM_RD;
            end else begin
               state_in = S_NSKIP_EV;
            end
         end
         S_NSKIP_EV: begin
            if (!sts.byte_zero) begin
               cmd.start_op = START_IDX;
               cmd.em_init  = 1'b1;
               state_in     = S_EM_RD;
            end else begin
               cmd.idx_op  = IDX_INC;
               cmd.cnt_inc = 1'b1;
               state_in    = S_NSKIP_RD;
            end
         end
         S_PREV_RD: begin
            if (sts.cnt_full) begin
               cmd.emit = EMIT_FAIL_CUR;
               state_in = S_IDLE;
            end else begin
               state_in = S_PREV_EV;
            end
         end
         S_PREV_EV: begin
            if (!sts.byte_zero) begin
               cmd.phase_set = 1'b1;
               if (sts.at_tail) begin
                  cmd.start_op = START_IDX;
                  state_in     = S_PREV_GO;
               end else begin
                  cmd.idx_op  = IDX_DEC;
                  cmd.cnt_inc = 1'b1;
                  state_in    = S_PREV_RD;
               end
            end else if (sts.phase) begin
               cmd.start_op = START_IDXP1;
               state_in     = S_PREV_GO;
            end else if (sts.at_tail) begin
               cmd.emit = EMIT_FAIL_CUR;
               state_in = S_IDLE;
            end else begin
               cmd.idx_op  = IDX_DEC;
               cmd.cnt_inc = 1'b1;
               state_in    = S_PREV_RD;
            end
         end
         S_PREV_GO: begin
            if (sts.start_eq_cur) begin
               cmd.emit = EMIT_FAIL_CUR;
               state_in = S_IDLE;
            end else begin
               cmd.idx_op  = IDX_START;
               cmd.em_init = 1'b1;
               state_in    = S_EM_RD;
            end
         end
         S_EM_RD: begin
            state_in = (sts.cnt_emax || sts.at_head) ? S_EM_FIN : S_EM_EV;
         end
         S_EM_EV: begin
            if (sts.byte_zero) begin
               state_in = S_EM_FIN;
            end else begin
               if (sts.pend_v) begin
                  cmd.emit = EMIT_PEND_MID;
               end
               cmd.pend_load = 1'b1;
               cmd.cnt_inc   = 1'b1;
               cmd.idx_op    = IDX_INC;
               state_in      = S_EM_RD;
            end
         end
         S_EM_FIN: begin
            cmd.emit = sts.pend_v ? EMIT_PEND_LAST : EMIT_EMPTY;
            if (sts.rtype == REQ_DEQ) begin
               cmd.cnt_clr = 1'b1;
               state_in    = S_DSKIP_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DSKIP_RD: begin
            if (sts.at_head || sts.cnt_full) begin
               cmd.tail_set = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_DSKIP_EV;
            end
         end
         S_DSKIP_EV: begin
            if (!sts.byte_zero) begin
               cmd.tail_set = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.idx_op  = IDX_INC;
               cmd.cnt_inc = 1'b1;
               state_in    = S_DSKIP_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

/* rtl/shrb_dp.sv */
`default_nettype none
module shrb_dp
   import shrb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [REQ_W-1:0]  req_type,
   input  wire logic [CHAR_W-1:0] req_char_in,
   input  wire logic [LEN_W-1:0]  req_str_len,
   input  wire logic              req_char_last,
   input  wire logic [CUR_W-1:0]  req_cursor_in,
   input  wire cmd_type           cmd,
   output sts_type                sts,
   output logic                   rsp_strobe,
   output logic [CHAR_W-1:0]      rsp_char_out,
   output logic                   rsp_out_last,
   output logic [STAT_W-1:0]      rsp_status,
   output logic [CUR_W-1:0]       rsp_cursor_out
);
   // latched item
   logic [REQ_W-1:0]  rtype_ff;
   logic [CHAR_W-1:0] char_ff;
   logic [LEN_W-1:0]  rlen_ff;
   logic              last_ff;
   logic [IDX_W-1:0]  cur_ff;

   // buffer state
   logic [IDX_W-1:0]    head_ff, head_in, tail_ff, tail_in, wr_ff, wr_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic                active_ff, active_in;
   logic [BUF_SIZE-1:0] vld_ff, vld_in;
   logic                vq_ff;

   // scan state
   logic [IDX_W-1:0]  idx_ff, idx_in, start_ff, start_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              phase_ff, phase_in;
   logic [CHAR_W-1:0] pend_ff, pend_in;
   logic              pend_v_ff, pend_v_in;

   // result register
   logic              strobe_ff, strobe_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic              olast_ff, olast_in;
   logic [STAT_W-1:0] stat_ff, stat_in;
   logic [CUR_W-1:0]  ocur_ff, ocur_in;

   logic [CHAR_W-1:0] rdata, byte_rd;
   logic [CNT_W-1:0]  size, room, hs, nhs;
   logic              wrap, push;
   logic [IDX_W-1:0]  tail_a, nh;

   shrb_ram #(.WIDTH(CHAR_W), .DEPTH(BUF_SIZE)) u_ram (
      .clock (clock),
      .we    (cmd.wr_byte),
      .waddr (wr_ff),
      .wdata (char_ff),
      .raddr (idx_ff),
      .rdata (rdata)
   );

   assign byte_rd = vq_ff ? rdata : '0;

   // space reservation for a new string
   always_comb begin
      size   = CNT_W'(rlen_ff) + CNT_W'(1);
      room   = CNT_FULL - {1'b0, head_ff};
      wrap   = (size > room);
      hs     = {1'b0, head_ff} + size;
      tail_a = (wrap && (hs > {1'b0, tail_ff})) ? size[IDX_W-1:0] : tail_ff;
      nh     = wrap ? '0 : head_ff;
      nhs    = {1'b0, nh} + size;
      push   = (nh < tail_a) && ({1'b0, tail_a} <= nhs);
   end

   always_comb begin
      sts.rtype        = rtype_ff;
      sts.active       = active_ff;
      sts.len_bad      = (rlen_ff == '0) || ({1'b0, rlen_ff} >= LEN_LIMIT);
      sts.last         = last_ff;
      sts.h_eq_t       = (head_ff == tail_ff);
      sts.h_eq_cur     = (head_ff == cur_ff);
      sts.t_eq_cur     = (tail_ff == cur_ff);
      sts.push         = push;
      sts.at_head      = (idx_ff == head_ff);
      sts.at_tail      = (idx_ff == tail_ff);
      sts.cnt_full     = (cnt_ff == CNT_FULL);
      sts.cnt_emax     = (cnt_ff == CNT_EMAX);
      sts.byte_zero    = (byte_rd == '0);
      sts.phase        = phase_ff;
      sts.pend_v       = pend_v_ff;
      sts.store_ok     = (LEN_W'(IDX_W'(wr_ff - head_ff)) < len_ff);
      sts.start_eq_cur = (start_ff == cur_ff);
   end

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      wr_in     = wr_ff;
      len_in    = len_ff;
      active_in = active_ff;
      vld_in    = vld_ff;
      if (cmd.reserve) begin
         head_in   = nh;
         wr_in     = nh;
         tail_in   = tail_a;
         len_in    = rlen_ff;
         active_in = 1'b1;
         if (wrap) begin
            for (int i = 0; i < BUF_SIZE; i++) begin
               if (IDX_W'(i) >= head_ff) begin
                  vld_in[i] = 1'b0;
               end
            end
         end
      end
      if (cmd.tail_set) begin
         tail_in = idx_ff;
      end
      if (cmd.wr_byte) begin
         vld_in[wr_ff] = 1'b1;
         wr_in         = wr_ff + IDX_W'(1);
      end
      if (cmd.fin_enq) begin
         // the terminator reads as zero once its valid bit drops
         vld_in[wr_ff] = 1'b0;
         head_in       = wr_ff + IDX_W'(1);
         wr_in         = wr_ff + IDX_W'(1);
         active_in     = 1'b0;
      end
   end

   always_comb begin
      unique case (cmd.idx_op)
         IDX_HOLD:  idx_in = idx_ff;
         IDX_CUR:   idx_in = cur_ff;
         IDX_CURM1: idx_in = cur_ff - IDX_W'(1);
         IDX_INC:   idx_in = idx_ff + IDX_W'(1);
         IDX_DEC:   idx_in = idx_ff - IDX_W'(1);
         IDX_TAIL:  idx_in = tail_ff;
         IDX_RES:   idx_in = nhs[IDX_W-1:0];
         IDX_START: idx_in = start_ff;
         default:   idx_in = idx_ff;
      endcase
      unique case (cmd.start_op)
         START_HOLD:  start_in = start_ff;
         START_IDX:   start_in = idx_ff;
         START_IDXP1: start_in = idx_ff + IDX_W'(1);
         START_TAIL:  start_in = tail_ff;
         default:     start_in = start_ff;
      endcase
      cnt_in = cnt_ff;
      if (cmd.cnt_clr || cmd.em_init) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      phase_in = phase_ff;
      if (cmd.phase_clr) begin
         phase_in = 1'b0;
      end else if (cmd.phase_set) begin
         phase_in = 1'b1;
      end
      pend_in   = pend_ff;
      pend_v_in = pend_v_ff;
      if (cmd.em_init) begin
         pend_v_in = 1'b0;
      end else if (cmd.pend_load) begin
         pend_in   = byte_rd;
         pend_v_in = 1'b1;
      end
   end

   always_comb begin
      strobe_in = 1'b1;
      ch_in     = '0;
      olast_in  = 1'b1;
      stat_in   = ST_OK;
      ocur_in   = CUR_W'(start_ff);
      unique case (cmd.emit)
         EMIT_NONE:      strobe_in = 1'b0;
         EMIT_BAD_LEN: begin
            stat_in = ST_BAD_LEN;
            ocur_in = CUR_W'(head_ff);
         end
         EMIT_FAIL_CUR: begin
            stat_in = ST_NONE;
            ocur_in = CUR_W'(cur_ff);
         end
         EMIT_FAIL_TAIL: begin
            stat_in = ST_NONE;
            ocur_in = CUR_W'(tail_ff);
         end
         EMIT_ENQ:       ocur_in = CUR_W'(head_ff);
         EMIT_PEND_MID: begin
            ch_in    = pend_ff;
            olast_in = 1'b0;
         end
         EMIT_PEND_LAST: ch_in = pend_ff;
         EMIT_EMPTY:     ch_in = '0;
         default:        strobe_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         wr_ff     <= '0;
         len_ff    <= '0;
         active_ff <= 1'b0;
         vld_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         wr_ff     <= wr_in;
         len_ff    <= len_in;
         active_ff <= active_in;
         vld_ff    <= vld_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         rtype_ff <= req_type;
         char_ff  <= req_char_in;
         rlen_ff  <= req_str_len;
         last_ff  <= req_char_last;
         cur_ff   <= req_cursor_in[IDX_W-1:0];
      end
      vq_ff     <= vld_ff[idx_ff];
      idx_ff    <= idx_in;
      start_ff  <= start_in;
      cnt_ff    <= cnt_in;
      phase_ff  <= phase_in;
      pend_ff   <= pend_in;
      pend_v_ff <= pend_v_in;
      ch_ff     <= ch_in;
      olast_ff  <= olast_in;
      stat_ff   <= stat_in;
      ocur_ff   <= ocur_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_char_out   = ch_ff;
   assign rsp_out_last   = olast_ff;
   assign rsp_status     = stat_ff;
   assign rsp_cursor_out = ocur_ff;
endmodule
`default_nettype wire

/* rtl/string_history_ring_buffer_unit.sv */
// String history ring buffer: a 64-byte store of NUL-separated strings.
// Request channel: present req_* with start high; the item is taken on the
// clock edge where start is high and busy is low. req_type picks enqueue
// byte, dequeue oldest string, browse previous or browse next.
// Result channel: each result is valid for one cycle while rsp_strobe is high;
// the receiver must take it then, there is no back pressure. rsp_out_last
// marks the final result of an item.
// Timing: an enqueue byte goes from start through dispatch and a write state
// back to idle; the first byte of a string also passes a space reservation
// state, plus a tail scan when it pushes the tail, and the last byte adds a
// state for the terminator and its result. Queries run a controller that
// reads the byte store in alternating read and evaluate states (address,
// then registered read data); the memory's registered read port sets this
// pattern. Results are registered and appear in the cycle after the
// controller emits them.
// Reset: synchronous, active high; head, tail and write pointers clear, and
// per-entry valid bits drop so the whole store reads as zero at once.
`default_nettype none
module string_history_ring_buffer_unit
   import shrb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [REQ_W-1:0]  req_type,
   input  wire logic [CHAR_W-1:0] req_char_in,
   input  wire logic [LEN_W-1:0]  req_str_len,
   input  wire logic              req_char_last,
   input  wire logic [CUR_W-1:0]  req_cursor_in,
   output logic                   rsp_strobe,
   output logic [CHAR_W-1:0]      rsp_char_out,
   output logic                   rsp_out_last,
   output logic [STAT_W-1:0]      rsp_status,
   output logic [CUR_W-1:0]       rsp_cursor_out
);
   cmd_type cmd;
   sts_type sts;

   // sequence the scans and pointer updates
   shrb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // hold the store, pointers and result register
   shrb_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_type       (req_type),
      .req_char_in    (req_char_in),
      .req_str_len    (req_str_len),
      .req_char_last  (req_char_last),
      .req_cursor_in  (req_cursor_in),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_strobe     (rsp_strobe),
      .rsp_char_out   (rsp_char_out),
      .rsp_out_last   (rsp_out_last),
      .rsp_status     (rsp_status),
      .rsp_cursor_out (rsp_cursor_out)
   );
endmodule
`default_nettype wire

/* rtl/shrb_chk.sv */
`default_nettype none
module shrb_chk
   import shrb_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_strobe,
   input wire logic [CHAR_W-1:0] rsp_char_out,
   input wire logic              rsp_out_last,
   input wire logic [STAT_W-1:0] rsp_status
);
   // a taken item keeps the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   // error results carry no byte and close the item
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != ST_OK) |-> rsp_out_last && (rsp_char_out == '0))
      else $error("error result not a lone final result");

   // a result that is not the last one is a real string byte
   a_mid_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_out_last |-> (rsp_char_out != '0))
      else $error("intermediate result without a byte");

   // no results appear out of a long idle stretch
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy && $past(!busy) && $past(!reset) |-> !rsp_strobe)
      else $error("result while idle");
endmodule

bind string_history_ring_buffer_unit shrb_chk u_shrb_chk (.*);
`default_nettype wire
